>>> rtl/srdn_pkg.sv
// shared constants for the shadow ray direction normalizer
// no dependencies; used only by shadow_ray_direction_normalizer_unit
package srdn_pkg;

  // fixed field widths of the result channel
  localparam int OUT_W = 32;
  localparam int TAG_W = 32;

  // configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RX_Z = 2'd2;

  // direction magnitude limits of the 32-bit signed field, range limit of the 32-bit unsigned field
  localparam logic [OUT_W:0] MAG_POS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [OUT_W:0] MAG_NEG_LIM = 33'h0_8000_0000;
  localparam logic [OUT_W:0] DIST_LIM    = 33'h0_FFFF_FFFF;

endpackage

>>> rtl/srdn_div.sv
// pipelined restoring divider, one quotient bit per stage
// gives floor(num * 2^(STEPS-1) / den) for num <= den; uses no package items
module srdn_div #(
  parameter int W     = 66,
  parameter int STEPS = 61
) (
  input  logic             clk,
  input  logic [W-1:0]     num,
  input  logic [W-1:0]     den,
  output logic [STEPS-1:0] quo
);

  logic [W-1:0]     rem_r [0:STEPS-1];
  logic [W-1:0]     den_r [0:STEPS-1];
  logic [STEPS-1:0] quo_r [0:STEPS];

  assign rem_r[0] = num;
  assign den_r[0] = den;
  assign quo_r[0] = '0;
  assign quo      = quo_r[STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    // first step tests the integer bit, later steps shift the remainder
    if (k == 0) begin : g_first
      assign trial = {1'b0, rem_r[k]};
    end else begin : g_next
      assign trial = {rem_r[k], 1'b0};
    end
    assign ge   = trial >= {1'b0, den_r[k]};
    assign diff = ge ? trial - {1'b0, den_r[k]} : trial;

    always_ff @(posedge clk) begin
      quo_r[k+1] <= {quo_r[k][STEPS-2:0], ge};
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k+1] <= diff[W-1:0];
        den_r[k+1] <= den_r[k];
      end
    end
  end

endmodule

>>> rtl/srdn_isqrt.sv
// pipelined integer square root, one root bit per stage
// root = floor(sqrt(x)) for an even input width XW; uses no package items
module srdn_isqrt #(
  parameter int XW = 62
) (
  input  logic              clk,
  input  logic [XW-1:0]     x,
  output logic [XW/2-1:0]   root
);

  localparam int N  = XW / 2;
  localparam int RW = N + 3;

  logic [RW-1:0] rem_r  [0:N-1];
  logic [N-1:0]  root_r [0:N];
  logic [XW-1:0] x_r    [0:N-1];

  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign x_r[0]    = x;
  assign root      = root_r[N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [1:0]    pair;
    logic [RW-1:0] rr;
    logic [RW-1:0] trial;
    logic          ge;

    // bring down two bits and try the next root bit
    assign pair  = x_r[j][XW-1-2*j -: 2];
    assign rr    = {rem_r[j][RW-3:0], pair};
    assign trial = {1'b0, root_r[j], 2'b01};
    assign ge    = rr >= trial;

    always_ff @(posedge clk) begin
      root_r[j+1] <= {root_r[j][N-2:0], ge};
    end

    if (j < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[j+1] <= ge ? rr - trial : rr;
        x_r[j+1]   <= x_r[j];
      end
    end
  end

endmodule

>>> rtl/shadow_ray_direction_normalizer_unit.sv
// shadow ray direction normalizer: unit vector and range from a point to the receiver
// results pass stages a to c, the divider and root pipelines, then the output register
// throughput one ray per cycle; set by the bit-per-stage divider and root pipelines
// synchronous active-low reset clears valid line and receiver registers; busy high in reset
// depends on srdn_pkg, srdn_div, srdn_isqrt
module shadow_ray_direction_normalizer_unit #(
  parameter int COORD_BITS    = 31,
  parameter int DIR_FRAC_BITS = 30
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // ray input
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        in_origin_x,
  input  logic signed [COORD_BITS-1:0]        in_origin_y,
  input  logic signed [COORD_BITS-1:0]        in_origin_z,
  input  logic [srdn_pkg::TAG_W-1:0]          in_ray_tag,
  input  logic                                in_last_ray,
  // result output
  output logic                                out_valid,
  output logic signed [srdn_pkg::OUT_W-1:0]   out_unit_x,
  output logic signed [srdn_pkg::OUT_W-1:0]   out_unit_y,
  output logic signed [srdn_pkg::OUT_W-1:0]   out_unit_z,
  output logic [srdn_pkg::OUT_W-1:0]          out_distance,
  output logic                                out_zero_range,
  output logic [srdn_pkg::TAG_W-1:0]          out_ray_tag_out,
  output logic                                out_last_ray_out,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srdn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);

  localparam int CW       = COORD_BITS;
  localparam int MW       = CW + 1;
  localparam int PW       = 2 * MW;
  localparam int SW       = PW + 2;
  localparam int QW       = 2 * DIR_FRAC_BITS + 1;
  localparam int QXW      = QW + 1;
  localparam int UW       = QXW / 2;
  localparam int DRW      = SW / 2;
  localparam int OW       = srdn_pkg::OUT_W;
  localparam int UXW      = (UW > OW + 1) ? UW : OW + 1;
  localparam int DXW      = (DRW > OW + 1) ? DRW : OW + 1;
  localparam int DIR_LAT  = QW + UW;
  localparam int DIST_LAT = DRW;
  localparam int LAT      = (DIR_LAT > DIST_LAT) ? DIR_LAT : DIST_LAT;
  localparam int NV       = 3 + LAT + 1;
  localparam int SBW      = srdn_pkg::TAG_W + 1 + 3 + 1;

  logic accept;
  logic [NV-1:0] vld_r;

  assign busy      = !rst_n;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // receiver position registers
  logic signed [CW-1:0] rx_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r[0] <= '0;
      rx_r[1] <= '0;
      rx_r[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srdn_pkg::REG_RX_X: rx_r[0] <= cfg_data;
        srdn_pkg::REG_RX_Y: rx_r[1] <= cfg_data;
        srdn_pkg::REG_RX_Z: rx_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid line follows every ray through all stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NV-2:0], accept};
    end
  end

  logic signed [CW-1:0] org [0:2];
  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;

  logic [MW-1:0] mag_r [0:2];
  logic [2:0]    neg_a_r, neg_b_r, neg_c_r;
  logic [PW-1:0] sq_r  [0:2];
  logic [SW-1:0] num_r [0:2];
  logic [SW-1:0] s_r;
  logic [UW-1:0] uroot [0:2];
  logic [UW-1:0] uroot_d [0:2];

  logic [srdn_pkg::TAG_W-1:0] tag_a_r, tag_b_r, tag_c_r;
  logic                       last_a_r, last_b_r, last_c_r;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [MW-1:0] d;
    logic [QW-1:0]        quo;

    // stage a: difference and magnitude
    assign d = MW'(rx_r[g]) - MW'(org[g]);
    always_ff @(posedge clk) begin
      mag_r[g]   <= d[MW-1] ? MW'(-d) : MW'(d);
      neg_a_r[g] <= d[MW-1];
    end

    // stage b: square, stage c: align numerator with the sum
    always_ff @(posedge clk) begin
      sq_r[g]  <= PW'(mag_r[g]) * PW'(mag_r[g]);
      num_r[g] <= SW'(sq_r[g]);
    end

    // quotient mag^2 * 2^(2F) / s, then its root gives the unit component
    srdn_div #(.W(SW), .STEPS(QW)) u_div (
      .clk (clk),
      .num (num_r[g]),
      .den (s_r),
      .quo (quo)
    );

    srdn_isqrt #(.XW(QXW)) u_uroot (
      .clk  (clk),
      .x    ({1'b0, quo}),
      .root (uroot[g])
    );

    // align with the longer of the two paths
    logic [UW-1:0] udl_r [0:LAT-DIR_LAT];
    assign udl_r[0]  = uroot[g];
    assign uroot_d[g] = udl_r[LAT-DIR_LAT];
    for (genvar i = 0; i < LAT - DIR_LAT; i++) begin : g_udl
      always_ff @(posedge clk) begin
        udl_r[i+1] <= udl_r[i];
      end
    end
  end

  // sideband through stages a to c, then the sum of squares
  always_ff @(posedge clk) begin
    tag_a_r  <= in_ray_tag;
    last_a_r <= in_last_ray;
    tag_b_r  <= tag_a_r;
    last_b_r <= last_a_r;
    neg_b_r  <= neg_a_r;
    tag_c_r  <= tag_b_r;
    last_c_r <= last_b_r;
    neg_c_r  <= neg_b_r;
    s_r      <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  // range root
  logic [DRW-1:0] droot;
  logic [DRW-1:0] droot_d;

  srdn_isqrt #(.XW(SW)) u_droot (
    .clk  (clk),
    .x    (s_r),
    .root (droot)
  );

  logic [DRW-1:0] ddl_r [0:LAT-DIST_LAT];
  assign ddl_r[0] = droot;
  assign droot_d  = ddl_r[LAT-DIST_LAT];
  for (genvar i = 0; i < LAT - DIST_LAT; i++) begin : g_ddl
    always_ff @(posedge clk) begin
      ddl_r[i+1] <= ddl_r[i];
    end
  end

  // sideband delay line: tag, last, signs, zero range
  logic [SBW-1:0] sdl_r [0:LAT];
  assign sdl_r[0] = {tag_c_r, last_c_r, neg_c_r, (s_r == '0)};
  for (genvar i = 0; i < LAT; i++) begin : g_sdl
    always_ff @(posedge clk) begin
      sdl_r[i+1] <= sdl_r[i];
    end
  end

  logic [srdn_pkg::TAG_W-1:0] tag_e;
  logic                       last_e;
  logic [2:0]                 neg_e;
  logic                       zero_e;
  assign {tag_e, last_e, neg_e, zero_e} = sdl_r[LAT];

  // output stage: saturate, apply sign, force zero on zero range
  logic signed [OW-1:0] unit_r [0:2];
  logic [OW-1:0]        dist_r;
  logic                 zero_r;
  logic [srdn_pkg::TAG_W-1:0] tag_r;
  logic                 last_r;

  for (genvar g = 0; g < 3; g++) begin : g_out
    logic [UXW-1:0] lim;
    logic [UXW-1:0] rx;
    logic [UXW-1:0] m;
    logic [UXW-1:0] sv;

    assign lim = neg_e[g] ? UXW'(srdn_pkg::MAG_NEG_LIM) : UXW'(srdn_pkg::MAG_POS_LIM);
    assign rx  = UXW'(uroot_d[g]);
    assign m   = (rx > lim) ? lim : rx;
    assign sv  = neg_e[g] ? UXW'(-m) : m;

    always_ff @(posedge clk) begin
      unit_r[g] <= zero_e ? '0 : sv[OW-1:0];
    end
  end

  logic [DXW-1:0] dx;
  assign dx = DXW'(droot_d);

  always_ff @(posedge clk) begin
    if (zero_e) begin
      dist_r <= '0;
    end else if (dx > DXW'(srdn_pkg::DIST_LIM)) begin
      dist_r <= '1;
    end else begin
      dist_r <= dx[OW-1:0];
    end
    zero_r <= zero_e;
    tag_r  <= tag_e;
    last_r <= last_e;
  end

  assign out_valid        = vld_r[NV-1];
  assign out_unit_x       = unit_r[0];
  assign out_unit_y       = unit_r[1];
  assign out_unit_z       = unit_r[2];
  assign out_distance     = dist_r;
  assign out_zero_range   = zero_r;
  assign out_ray_tag_out  = tag_r;
  assign out_last_ray_out = last_r;

  // every accepted ray leaves after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##NV out_valid)
    else $error("accepted ray did not leave after the pipeline latency");

  // zero range carries a zero direction and range
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_range |-> out_unit_x == '0 && out_unit_y == '0 &&
      out_unit_z == '0 && out_distance == '0)
    else $error("zero range result with nonzero direction or range");

  // a nonzero vector has a range of at least one
  a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_range |-> out_distance != '0)
    else $error("nonzero vector with zero range");

endmodule
